[sv/awb_pkg.sv]
// Shared types and constants for the affine warp block.
// No dependencies; imported by the top level and the checker.
package awb_pkg;

  localparam int SRC_W_MAX  = 256;
  localparam int SRC_H_MAX  = 256;
  localparam int COORD_W    = 8;                 // sample/pixel coordinate bits
  localparam int BANK_AW    = 2 * (COORD_W - 1); // address bits of one luma bank / chroma plane
  localparam int SIZE_W     = 9;

  localparam logic [7:0]        CHROMA_NEUTRAL = 8'h80;
  localparam logic [7:0]        LUMA_MAX       = 8'd255;
  localparam logic [SIZE_W-1:0] SIZE_LIMIT     = SIZE_W'(SRC_W_MAX);
  localparam logic [SIZE_W-1:0] SIZE_LIMIT_H   = SIZE_W'(SRC_H_MAX);

  typedef enum logic [1:0] {
    MODE_LOAD_Y = 2'd0,
    MODE_LOAD_U = 2'd1,
    MODE_LOAD_V = 2'd2,
    MODE_WARP   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_XGX = 3'd0,
    CFG_XGY = 3'd1,
    CFG_XOF = 3'd2,
    CFG_YGX = 3'd3,
    CFG_YGY = 3'd4,
    CFG_YOF = 3'd5,
    CFG_SRCW = 3'd6,
    CFG_SRCH = 3'd7
  } cfg_idx_e;

endpackage

[sv/awb_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; used for the luma banks and chroma planes.
module awb_ram #(
  parameter int AW = 14,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[sv/affine_warp_bilinear_yuv420.sv]
// Affine warp of a YUV420 frame with bilinear luma interpolation, top level.
// Depends on awb_pkg and awb_ram.
//
// A user first loads the source frame one sample per word (mode 0 luma, 1 U,
// 2 V), then sends warp words (mode 3) with output column/row. Every word,
// load or warp, is accepted at one per clock unless the pipe holds; a warp word
// yields one result word through six pipe registers (two multiply/add stages,
// range check, source RAM read, two interpolation stages). Loads flow
// down the same pipe and write the source RAMs at the same stage where warps
// read them, so a warp always sees every load accepted before it. Luma is held
// in four 128x128 banks split by row and column parity, so the 2x2 neighborhood
// is one read per bank in the same cycle; U and V are 128x128 planes with one read
// each. The whole pipe holds only while a result is waiting and the output is
// stalled. Config registers must be written while the pipe is empty;
// cfg_ready_o is always high.
module affine_warp_bilinear_yuv420 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  col_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_col_o,
  output logic [7:0]  out_row_o,
  output logic [7:0]  luma_o,
  output logic        luma_written_o,
  output logic [7:0]  chroma_u_o,
  output logic [7:0]  chroma_v_o,
  output logic        chroma_written_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import awb_pkg::*;

  // ---------------- config registers ----------------
  logic signed [31:0] xgx_q, xgy_q, xof_q, ygx_q, ygy_q, yof_q;
  logic [SIZE_W-1:0]  srcw_q, srch_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xgx_q  <= 32'sd65536;
      xgy_q  <= '0;
      xof_q  <= '0;
      ygx_q  <= '0;
      ygy_q  <= 32'sd65536;
      yof_q  <= '0;
      srcw_q <= SIZE_LIMIT;
      srch_q <= SIZE_LIMIT_H;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_XGX:  xgx_q  <= cfg_data_i;
        CFG_XGY:  xgy_q  <= cfg_data_i;
        CFG_XOF:  xof_q  <= cfg_data_i;
        CFG_YGX:  ygx_q  <= cfg_data_i;
        CFG_YGY:  ygy_q  <= cfg_data_i;
        CFG_YOF:  yof_q  <= cfg_data_i;
        CFG_SRCW: srcw_q <= cfg_data_i[SIZE_W-1:0];
        CFG_SRCH: srch_q <= cfg_data_i[SIZE_W-1:0];
        default:  ;
      endcase
    end
  end

  // global advance: pipe holds only when a result waits on a stalled sink
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- stage 1: products ----------------
  logic               v1_q;
  mode_e              mode1_q;
  logic [7:0]         col1_q, row1_q, pix1_q;
  logic signed [40:0] pxx_q, pxy_q, pyx_q, pyy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode1_q <= mode_e'(mode_i);
      col1_q  <= col_i;
      row1_q  <= row_i;
      pix1_q  <= pixel_i;
      pxx_q   <= xgx_q * $signed({1'b0, col_i});
      pxy_q   <= xgy_q * $signed({1'b0, row_i});
      pyx_q   <= ygx_q * $signed({1'b0, col_i});
      pyy_q   <= ygy_q * $signed({1'b0, row_i});
    end
  end

  // ---------------- stage 2: source position (Q.16) ----------------
  logic               v2_q;
  mode_e              mode2_q;
  logic [7:0]         col2_q, row2_q, pix2_q;
  logic signed [42:0] rx_q, ry_q;
  logic signed [42:0] rx_d, ry_d;

  assign rx_d = {{2{pxx_q[40]}}, pxx_q} + {{2{pxy_q[40]}}, pxy_q} + {{11{xof_q[31]}}, xof_q};
  assign ry_d = {{2{pyx_q[40]}}, pyx_q} + {{2{pyy_q[40]}}, pyy_q} + {{11{yof_q[31]}}, yof_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode2_q <= mode1_q;
      col2_q  <= col1_q;
      row2_q  <= row1_q;
      pix2_q  <= pix1_q;
      rx_q    <= rx_d;
      ry_q    <= ry_d;
    end
  end

  // ---------------- stage 3: range check and RAM addresses ----------------
  logic [SIZE_W-1:0] w_lim, h_lim;
  logic              in_rng;
  logic [7:0]        tx, ty;
  logic [BANK_AW-1:0] la_d [4];
  logic [BANK_AW-1:0] ca_d;

  assign w_lim = (srcw_q > SIZE_LIMIT) ? SIZE_LIMIT : srcw_q;
  assign h_lim = (srch_q > SIZE_LIMIT_H) ? SIZE_LIMIT_H : srch_q;
  assign tx    = rx_q[23:16];
  assign ty    = ry_q[23:16];

  // floor of both coordinates non-negative and within size-2
  assign in_rng = !rx_q[42] && !ry_q[42] && (w_lim >= SIZE_W'(2)) && (h_lim >= SIZE_W'(2))
               && (rx_q[42:16] <= {18'd0, w_lim - SIZE_W'(2)})
               && (ry_q[42:16] <= {18'd0, h_lim - SIZE_W'(2)});

  always_comb begin
    logic [7:0] rr, cc;
    rr = '0;
    cc = '0;
    for (int b = 0; b < 4; b++) begin
      // bank b = {row parity, col parity}; pick whichever of t, t+1 matches
      rr = ty + {7'd0, ty[0] ^ b[1]};
      cc = tx + {7'd0, tx[0] ^ b[0]};
      if (mode2_q == MODE_WARP) la_d[b] = {rr[7:1], cc[7:1]};
      else                      la_d[b] = {row2_q[7:1], col2_q[7:1]};
    end
    if (mode2_q == MODE_WARP) ca_d = {ty[7:1], tx[7:1]};
    else                      ca_d = {row2_q[6:0], col2_q[6:0]};
  end

  logic               v3_q;
  mode_e              mode3_q;
  logic [7:0]         col3_q, row3_q, pix3_q, fx3_q, fy3_q;
  logic               lw3_q, cw3_q, x03_q, y03_q, cok3_q;
  logic [BANK_AW-1:0] la3_q [4];
  logic [BANK_AW-1:0] ca3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode3_q <= mode2_q;
      col3_q  <= col2_q;
      row3_q  <= row2_q;
      pix3_q  <= pix2_q;
      fx3_q   <= rx_q[15:8];
      fy3_q   <= ry_q[15:8];
      lw3_q   <= in_rng;
      cw3_q   <= in_rng && !col2_q[0] && !row2_q[0];
      x03_q   <= tx[0];
      y03_q   <= ty[0];
      cok3_q  <= !col2_q[7] && !row2_q[7];
      la3_q   <= la_d;
      ca3_q   <= ca_d;
    end
  end

  // ---------------- stage 4: source RAMs (load writes, warp reads) ----------------
  logic [7:0] lrd [4];
  logic [7:0] urd, vrd;
  logic       wr_ok;

  assign wr_ok = adv && v3_q;

  for (genvar b = 0; b < 4; b++) begin : g_luma
    awb_ram #(.AW(BANK_AW), .DW(8)) u_luma (
      .clk_i   (clk_i),
      .we_i    (wr_ok && (mode3_q == MODE_LOAD_Y) && ({row3_q[0], col3_q[0]} == 2'(b))),
      .waddr_i (la3_q[b]),
      .wdata_i (pix3_q),
      .re_i    (adv),
      .raddr_i (la3_q[b]),
      .rdata_o (lrd[b])
    );
  end

  awb_ram #(.AW(BANK_AW), .DW(8)) u_cu (
    .clk_i   (clk_i),
    .we_i    (wr_ok && (mode3_q == MODE_LOAD_U) && cok3_q),
    .waddr_i (ca3_q),
    .wdata_i (pix3_q),
    .re_i    (adv),
    .raddr_i (ca3_q),
    .rdata_o (urd)
  );

  awb_ram #(.AW(BANK_AW), .DW(8)) u_cv (
    .clk_i   (clk_i),
    .we_i    (wr_ok && (mode3_q == MODE_LOAD_V) && cok3_q),
    .waddr_i (ca3_q),
    .wdata_i (pix3_q),
    .re_i    (adv),
    .raddr_i (ca3_q),
    .rdata_o (vrd)
  );

  logic       v4_q;
  logic [7:0] col4_q, row4_q, fx4_q, fy4_q;
  logic       lw4_q, cw4_q, x04_q, y04_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q && (mode3_q == MODE_WARP);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col4_q <= col3_q;
      row4_q <= row3_q;
      fx4_q  <= fx3_q;
      fy4_q  <= fy3_q;
      lw4_q  <= lw3_q;
      cw4_q  <= cw3_q;
      x04_q  <= x03_q;
      y04_q  <= y03_q;
    end
  end

  // ---------------- stage 5: horizontal lerp ----------------
  logic [7:0]  nw, ne, sw, se;
  logic [8:0]  fxc;
  logic [16:0] top_s, bot_s;

  assign nw    = lrd[{y04_q, x04_q}];
  assign ne    = lrd[{y04_q, ~x04_q}];
  assign sw    = lrd[{~y04_q, x04_q}];
  assign se    = lrd[{~y04_q, ~x04_q}];
  assign fxc   = 9'd256 - {1'b0, fx4_q};
  assign top_s = fxc * {1'b0, nw} + {1'b0, fx4_q} * {1'b0, ne};
  assign bot_s = fxc * {1'b0, sw} + {1'b0, fx4_q} * {1'b0, se};

  logic       v5_q;
  logic [7:0] col5_q, row5_q, fy5_q, top5_q, bot5_q, u5_q, cv5_q;
  logic       lw5_q, cw5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col5_q <= col4_q;
      row5_q <= row4_q;
      fy5_q  <= fy4_q;
      top5_q <= top_s[15:8];
      bot5_q <= bot_s[15:8];
      u5_q   <= urd;
      cv5_q  <= vrd;
      lw5_q  <= lw4_q;
      cw5_q  <= cw4_q;
    end
  end

  // ---------------- stage 6: vertical lerp and output register ----------------
  logic [8:0]  fyc;
  logic [16:0] mix_s;
  logic [8:0]  mix_sh;
  logic [7:0]  luma_d;

  assign fyc    = 9'd256 - {1'b0, fy5_q};
  assign mix_s  = fyc * {1'b0, top5_q} + {1'b0, fy5_q} * {1'b0, bot5_q};
  assign mix_sh = mix_s[16:8];
  assign luma_d = (mix_sh > {1'b0, LUMA_MAX}) ? LUMA_MAX : mix_sh[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_col_o        <= col5_q;
      out_row_o        <= row5_q;
      luma_o           <= lw5_q ? luma_d : 8'd0;
      luma_written_o   <= lw5_q;
      chroma_u_o       <= cw5_q ? u5_q : CHROMA_NEUTRAL;
      chroma_v_o       <= cw5_q ? cv5_q : CHROMA_NEUTRAL;
      chroma_written_o <= cw5_q;
    end
  end

endmodule

[sv/awb_checker.sv]
// Port-level checks for the affine warp block, bound to the top level.
// Depends on awb_pkg and affine_warp_bilinear_yuv420.
module awb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_col_o,
  input logic [7:0] out_row_o,
  input logic [7:0] luma_o,
  input logic       luma_written_o,
  input logic [7:0] chroma_u_o,
  input logic [7:0] chroma_v_o,
  input logic       chroma_written_o
);
  import awb_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_col_o) && $stable(luma_o))
    else $error("stalled result word changed");

  a_luma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !luma_written_o |-> luma_o == 8'd0)
    else $error("luma not zero on unwritten pixel");

  a_chroma_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chroma_written_o |->
      chroma_u_o == CHROMA_NEUTRAL && chroma_v_o == CHROMA_NEUTRAL)
    else $error("chroma not neutral on unwritten pixel");

  a_chroma_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chroma_written_o |-> luma_written_o && !out_col_o[0] && !out_row_o[0])
    else $error("chroma written at odd position or out of range");

endmodule

bind affine_warp_bilinear_yuv420 awb_checker u_awb_checker (.*);
